[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and constants for the rotation matrix to quaternion
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    localparam int FIELD_W   = 18;
    localparam int FRAC_BITS = 16;

    localparam int RAD_W  = ((FIELD_W > FRAC_BITS + 1) ? FIELD_W : FRAC_BITS + 1) + 3;
    localparam int RADM_W = RAD_W - 1;
    localparam int SQ_W   = 2 * ((RADM_W + FRAC_BITS + 1) / 2);
    localparam int ROOT_W = SQ_W / 2;
    localparam int D_W    = FIELD_W + 1;
    localparam int MAG_W  = D_W;
    localparam int NUM_W  = ((MAG_W + FRAC_BITS > ROOT_W) ? MAG_W + FRAC_BITS : ROOT_W) + 1;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int QB     = FIELD_W;
    localparam int CW     = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;
    localparam int HW     = ROOT_W + FIELD_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic signed [FIELD_W-1:0] t_fix;
    typedef logic signed [RAD_W-1:0]   t_rad;
    typedef logic signed [D_W-1:0]     t_diff;
    typedef logic [MAG_W-1:0]          t_mag;

    localparam t_fix SAT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam t_rad ONE_RAD = {{(RAD_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [1:0] COMP_W = 2'd0;
    localparam logic [1:0] COMP_X = 2'd1;
    localparam logic [1:0] COMP_Y = 2'd2;
    localparam logic [1:0] COMP_Z = 2'd3;

    typedef enum logic [1:0] {
        CL_AX0,
        CL_AX1,
        CL_AX2,
        CL_TRACE
    } t_class;

    typedef struct packed {
        t_rad       rad;
        logic [1:0] p;
        t_diff      d0;
        t_diff      d1;
        t_diff      d2;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       valid;
        logic       bad;
        logic [1:0] p;
        t_mag       mag0;
        t_mag       mag1;
        t_mag       mag2;
        logic [2:0] neg;
    } t_sb1;

    typedef struct packed {
        logic       valid;
        logic       bad;
        logic [1:0] p;
        logic [2:0] neg;
        t_fix       half;
    } t_sb2;

    function automatic t_rad sx_rad(input t_fix v);
        sx_rad = {{(RAD_W-FIELD_W){v[FIELD_W-1]}}, v};
    endfunction

    function automatic t_diff sx_diff(input t_fix v);
        sx_diff = {{(D_W-FIELD_W){v[FIELD_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed Q2.16 to a unit quaternion.
// ----------------------------------------------------------------------------
// Takes one matrix per clock and returns one quaternion per clock in the
// same order while the output is not stalled. A matrix passes a classifier
// stage, a four-entry queue, a root input register, an 18-stage square root
// pipeline, a scaling stage, a 19-stage divider pipeline (three dividers
// side by side) and the output register. A stall on the output freezes the
// arithmetic pipeline; the queue then fills and the input stalls. o_invalid
// marks a result whose root argument was not positive, in which case the
// root is taken as one LSB.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r0c0,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r0c1,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r0c2,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r1c0,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r1c1,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r1c2,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r2c0,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r2c1,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m_r2c2,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_w,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_x,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_y,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_z,
    output logic                             o_invalid
);
    import rmq_pkg::*;

    logic    push;
    logic    pop;
    t_entry  push_entry;
    t_entry  head_entry;
    t_q_stat q_stat;

    rmq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_m_r0c0 (i_m_r0c0),
        .i_m_r0c1 (i_m_r0c1),
        .i_m_r0c2 (i_m_r0c2),
        .i_m_r1c0 (i_m_r1c0),
        .i_m_r1c1 (i_m_r1c1),
        .i_m_r1c2 (i_m_r1c2),
        .i_m_r2c0 (i_m_r2c0),
        .i_m_r2c1 (i_m_r2c1),
        .i_m_r2c2 (i_m_r2c2),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    rmq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    rmq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (q_stat),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_q_w     (o_q_w),
        .o_q_x     (o_q_x),
        .o_q_y     (o_q_y),
        .o_q_z     (o_q_z),
        .o_invalid (o_invalid)
    );

endmodule

`default_nettype wire

[rtl/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// Input register and classifier: picks the trace or diagonal case and forms
// the radicand and the three off-diagonal terms.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rmq_pkg::t_fix   i_m_r0c0,
    input  rmq_pkg::t_fix   i_m_r0c1,
    input  rmq_pkg::t_fix   i_m_r0c2,
    input  rmq_pkg::t_fix   i_m_r1c0,
    input  rmq_pkg::t_fix   i_m_r1c1,
    input  rmq_pkg::t_fix   i_m_r1c2,
    input  rmq_pkg::t_fix   i_m_r2c0,
    input  rmq_pkg::t_fix   i_m_r2c1,
    input  rmq_pkg::t_fix   i_m_r2c2,
    input  rmq_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output rmq_pkg::t_entry o_entry
);
    import rmq_pkg::*;

    logic   r_valid;
    t_fix   r_m00, r_m01, r_m02, r_m10, r_m11, r_m12, r_m20, r_m21, r_m22;
    t_class r_cls;

    logic   acc;
    t_rad   n_trace;
    logic   c1, c2;
    t_fix   mi;
    t_class n_cls;
    t_rad   a00, a11, a22;

    assign o_stall = r_valid && i_q_stat.full;
    assign o_push  = r_valid && !i_q_stat.full;
    assign acc     = i_valid && !o_stall;

    always_comb begin
        n_trace = sx_rad(i_m_r0c0) + sx_rad(i_m_r1c1) + sx_rad(i_m_r2c2);
        c1      = i_m_r1c1 > i_m_r0c0;
        mi      = c1 ? i_m_r1c1 : i_m_r0c0;
        c2      = i_m_r2c2 > mi;
        if (!n_trace[RAD_W-1] && (n_trace != '0)) begin
            n_cls = CL_TRACE;
        end else if (c2) begin
            n_cls = CL_AX2;
        end else if (c1) begin
            n_cls = CL_AX1;
        end else begin
            n_cls = CL_AX0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (acc) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_m00 <= i_m_r0c0;
            r_m01 <= i_m_r0c1;
            r_m02 <= i_m_r0c2;
            r_m10 <= i_m_r1c0;
            r_m11 <= i_m_r1c1;
            r_m12 <= i_m_r1c2;
            r_m20 <= i_m_r2c0;
            r_m21 <= i_m_r2c1;
            r_m22 <= i_m_r2c2;
            r_cls <= n_cls;
        end
    end

    assign a00 = sx_rad(r_m00);
    assign a11 = sx_rad(r_m11);
    assign a22 = sx_rad(r_m22);

    always_comb begin
        unique case (r_cls)
            CL_TRACE: begin
                o_entry.rad = a00 + a11 + a22 + ONE_RAD;
                o_entry.p   = COMP_W;
                o_entry.d0  = sx_diff(r_m21) - sx_diff(r_m12);
                o_entry.d1  = sx_diff(r_m02) - sx_diff(r_m20);
                o_entry.d2  = sx_diff(r_m10) - sx_diff(r_m01);
            end
            CL_AX0: begin
                o_entry.rad = a00 - a11 - a22 + ONE_RAD;
                o_entry.p   = COMP_X;
                o_entry.d0  = sx_diff(r_m21) - sx_diff(r_m12);
                o_entry.d1  = sx_diff(r_m10) + sx_diff(r_m01);
                o_entry.d2  = sx_diff(r_m20) + sx_diff(r_m02);
            end
            CL_AX1: begin
                o_entry.rad = a11 - a22 - a00 + ONE_RAD;
                o_entry.p   = COMP_Y;
                o_entry.d0  = sx_diff(r_m02) - sx_diff(r_m20);
                o_entry.d1  = sx_diff(r_m01) + sx_diff(r_m10);
                o_entry.d2  = sx_diff(r_m21) + sx_diff(r_m12);
            end
            default: begin
                o_entry.rad = a22 - a00 - a11 + ONE_RAD;
                o_entry.p   = COMP_Z;
                o_entry.d0  = sx_diff(r_m10) - sx_diff(r_m01);
                o_entry.d1  = sx_diff(r_m02) + sx_diff(r_m20);
                o_entry.d2  = sx_diff(r_m12) + sx_diff(r_m21);
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/rmq_queue.sv]
// ----------------------------------------------------------------------------
// rmq_queue
// Short flop queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rmq_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output rmq_pkg::t_entry  o_entry,
    output rmq_pkg::t_q_stat o_stat
);
    import rmq_pkg::*;

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;

    assign o_stat.full  = r_cnt == Q_CW'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_entry      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[rtl/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rmq_pkg::SQ_W-1:0]   i_x,
    output logic [rmq_pkg::ROOT_W-1:0] o_root
);
    import rmq_pkg::*;

    logic [ROOT_W+1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SQ_W-1:0]   r_x    [ROOT_W];

    genvar s;
    generate
        for (s = 0; s < ROOT_W; s++) begin : g_stage
            logic [ROOT_W+1:0] p_rem;
            logic [ROOT_W-1:0] p_root;
            logic [SQ_W-1:0]   p_x;
            logic [ROOT_W+1:0] sh_rem;
            logic [ROOT_W+1:0] trial;
            logic              ge;

            if (s == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_x    = i_x;
            end else begin : g_next
                assign p_rem  = r_rem[s-1];
                assign p_root = r_root[s-1];
                assign p_x    = r_x[s-1];
            end

            assign sh_rem = {p_rem[ROOT_W-1:0], p_x[SQ_W-1 -: 2]};
            assign trial  = {p_root, 2'b01};
            assign ge     = sh_rem >= trial;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= ge ? sh_rem - trial : sh_rem;
                    r_root[s] <= {p_root[ROOT_W-2:0], ge};
                    r_x[s]    <= {p_x[SQ_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider with an overflow check stage, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rmq_pkg::NUM_W-1:0] i_num,
    input  logic [rmq_pkg::DEN_W-1:0] i_den,
    output logic [rmq_pkg::QB-1:0]    o_q,
    output logic                      o_ovf
);
    import rmq_pkg::*;

    logic [CW-1:0]    r_rem [QB+1];
    logic [DEN_W-1:0] r_den [QB+1];
    logic [QB-1:0]    r_q   [QB+1];
    logic             r_ovf [QB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << QB);
        end
    end

    genvar s;
    generate
        for (s = 1; s <= QB; s++) begin : g_stage
            logic [CW-1:0] sh;
            logic          ge;

            assign sh = CW'(r_den[s-1]) << (QB - s);
            assign ge = r_rem[s-1] >= sh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? r_rem[s-1] - sh : r_rem[s-1];
                    r_den[s] <= r_den[s-1];
                    r_q[s]   <= {r_q[s-1][QB-2:0], ge};
                    r_ovf[s] <= r_ovf[s-1];
                end
            end
        end
    endgenerate

    assign o_q   = r_q[QB];
    assign o_ovf = r_ovf[QB];

endmodule

`default_nettype wire

[rtl/rmq_back.sv]
// ----------------------------------------------------------------------------
// rmq_back
// Arithmetic pipeline: root, half root, three scaled quotients, output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rmq_pkg::t_q_stat i_q_stat,
    input  rmq_pkg::t_entry  i_entry,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output rmq_pkg::t_fix    o_q_w,
    output rmq_pkg::t_fix    o_q_x,
    output rmq_pkg::t_fix    o_q_y,
    output rmq_pkg::t_fix    o_q_z,
    output logic             o_invalid
);
    import rmq_pkg::*;

    localparam logic [QB-1:0] HALF_RANGE = {1'b1, {(QB-1){1'b0}}};

    function automatic t_mag abs_d(input t_diff d);
        abs_d = d[D_W-1] ? t_mag'(-d) : t_mag'(d);
    endfunction

    function automatic t_fix fold(input logic [QB-1:0] q, input logic ovf, input logic neg);
        logic [QB-1:0] qc;
        qc = (ovf || (q > HALF_RANGE)) ? HALF_RANGE : q;
        if (neg) begin
            fold = -qc;
        end else if (qc == HALF_RANGE) begin
            fold = SAT_MAX;
        end else begin
            fold = qc;
        end
    endfunction

    logic              adv;
    t_sb1              n_s0;
    logic [SQ_W-1:0]   n_sq_in;
    t_sb1              r_s0;
    logic [SQ_W-1:0]   r_sq_in;
    t_sb1              r_sb1 [ROOT_W];
    logic [ROOT_W-1:0] root;
    t_sb1              sb1;
    logic [ROOT_W-1:0] root_eff;
    logic [ROOT_W:0]   half_w;
    t_sb2              n_p;
    logic [NUM_W-1:0]  n_num0, n_num1, n_num2;
    logic [DEN_W-1:0]  n_den;
    t_sb2              r_sb2 [QB+2];
    logic [NUM_W-1:0]  r_num0, r_num1, r_num2;
    logic [DEN_W-1:0]  r_den;
    logic [QB-1:0]     q0, q1, q2;
    logic              ovf0, ovf1, ovf2;
    t_sb2              sb2;
    t_fix              f0, f1, f2;
    logic              r_out_valid;
    t_fix              r_q_w, r_q_x, r_q_y, r_q_z;
    logic              r_invalid;

    assign adv   = !(r_out_valid && i_stall);
    assign o_pop = adv && !i_q_stat.empty;

    always_comb begin
        n_s0.valid = o_pop;
        n_s0.bad   = i_entry.rad[RAD_W-1] || (i_entry.rad == '0);
        n_s0.p     = i_entry.p;
        n_s0.mag0  = abs_d(i_entry.d0);
        n_s0.mag1  = abs_d(i_entry.d1);
        n_s0.mag2  = abs_d(i_entry.d2);
        n_s0.neg   = {i_entry.d2[D_W-1], i_entry.d1[D_W-1], i_entry.d0[D_W-1]};
        n_sq_in    = n_s0.bad ? '0
                   : SQ_W'({i_entry.rad[RADM_W-1:0], {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            for (int k = 0; k < ROOT_W; k++) begin
                r_sb1[k] <= '0;
            end
        end else if (adv) begin
            r_s0     <= n_s0;
            r_sb1[0] <= r_s0;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sb1[k] <= r_sb1[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_in <= n_sq_in;
        end
    end

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_x    (r_sq_in),
        .o_root (root)
    );

    always_comb begin
        sb1       = r_sb1[ROOT_W-1];
        root_eff  = sb1.bad ? ROOT_W'(1) : root;
        half_w    = ({1'b0, root_eff} + 1'b1) >> 1;
        n_den     = {root_eff, 1'b0};
        n_num0    = (NUM_W'(sb1.mag0) << FRAC_BITS) + NUM_W'(root_eff);
        n_num1    = (NUM_W'(sb1.mag1) << FRAC_BITS) + NUM_W'(root_eff);
        n_num2    = (NUM_W'(sb1.mag2) << FRAC_BITS) + NUM_W'(root_eff);
        n_p.valid = sb1.valid;
        n_p.bad   = sb1.bad;
        n_p.p     = sb1.p;
        n_p.neg   = sb1.neg;
        n_p.half  = (HW'(half_w) > HW'($unsigned(SAT_MAX))) ? SAT_MAX
                  : t_fix'(half_w[FIELD_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB + 1; k++) begin
                r_sb2[k] <= '0;
            end
        end else if (adv) begin
            r_sb2[0] <= n_p;
            for (int k = 1; k <= QB + 1; k++) begin
                r_sb2[k] <= r_sb2[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num0 <= n_num0;
            r_num1 <= n_num1;
            r_num2 <= n_num2;
            r_den  <= n_den;
        end
    end

    rmq_div u_div0 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_num0),
        .i_den (r_den),
        .o_q   (q0),
        .o_ovf (ovf0)
    );

    rmq_div u_div1 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_num1),
        .i_den (r_den),
        .o_q   (q1),
        .o_ovf (ovf1)
    );

    rmq_div u_div2 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_num2),
        .i_den (r_den),
        .o_q   (q2),
        .o_ovf (ovf2)
    );

    always_comb begin
        sb2 = r_sb2[QB+1];
        f0  = fold(q0, ovf0, sb2.neg[0]);
        f1  = fold(q1, ovf1, sb2.neg[1]);
        f2  = fold(q2, ovf2, sb2.neg[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= sb2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q_w     <= (sb2.p == COMP_W) ? sb2.half : f0;
            r_q_x     <= (sb2.p == COMP_X) ? sb2.half : ((sb2.p == COMP_W) ? f0 : f1);
            r_q_y     <= (sb2.p == COMP_Y) ? sb2.half
                       : ((sb2.p == COMP_Z) ? f2 : f1);
            r_q_z     <= (sb2.p == COMP_Z) ? sb2.half : f2;
            r_invalid <= sb2.bad;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_q_w     = r_q_w;
    assign o_q_x     = r_q_x;
    assign o_q_y     = r_q_y;
    assign o_q_z     = r_q_z;
    assign o_invalid = r_invalid;

endmodule

`default_nettype wire

[rtl/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic                               o_invalid,
    input logic signed [rmq_pkg::FIELD_W-1:0] o_q_w,
    input logic signed [rmq_pkg::FIELD_W-1:0] o_q_x,
    input logic signed [rmq_pkg::FIELD_W-1:0] o_q_y,
    input logic signed [rmq_pkg::FIELD_W-1:0] o_q_z
);
    import rmq_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_q_w) && $stable(o_q_x) && $stable(o_q_y)
            && $stable(o_q_z) && $stable(o_invalid))
        else $error("result word changed while stalled");

    a_clamped_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> (o_q_w == 1) || (o_q_x == 1) || (o_q_y == 1) || (o_q_z == 1))
        else $error("clamped root not reflected in result");

    a_root_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_q_w > 0) || (o_q_x > 0) || (o_q_y > 0) || (o_q_z > 0))
        else $error("no positive root component");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

`default_nettype wire
